@@ rtl/tilt_and_heading_angles_assert.svh @@
// assertion macros for the tilt and heading pipeline
`ifndef TILT_AND_HEADING_ANGLES_ASSERT_SVH
`define TILT_AND_HEADING_ANGLES_ASSERT_SVH
// expression must hold on every cycle out of reset
`define TAH_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("tah assertion failed");
// antecedent implies consequent in the same cycle
`define TAH_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tah assertion failed");
`endif

@@ rtl/tah_pkg.sv @@
// constants, types and angle table for the tilt and heading pipeline
`default_nettype none
package tah_pkg;
  localparam int DISPLAY_SIZE = 128;
  localparam int ANGLE_ITERATIONS = 16;
  localparam int DOT_W = $clog2(DISPLAY_SIZE);
  localparam int SQ_BITS = 24;
  localparam int RW = SQ_BITS + 2;
  localparam int CW = 36;
  localparam int ZW = 27;
  localparam int FRAC_BITS = 10;
  localparam int FRAC_HALF = 512;
  localparam int QUARTER_Z = 9000 * 1024;
  localparam int RECIP_100 = 167773;
  localparam int RECIP_SH = 24;
  localparam int S_SQ = 3;
  localparam int S_PRE = S_SQ + SQ_BITS;
  localparam int S_C0 = S_PRE + 1;
  localparam int S_P1 = S_C0 + ANGLE_ITERATIONS;
  localparam int S_OUT = S_P1 + 3;
  localparam logic [1:0] REG_DECL = 2'd0;
  localparam logic [1:0] REG_GAIN = 2'd1;
  localparam logic [1:0] REG_CX = 2'd2;
  localparam logic [1:0] REG_CY = 2'd3;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] mx;
    logic signed [15:0] my;
  } sample_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic zero;
  } cord_t;

  function automatic logic signed [ZW-1:0] atan_tab(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0: v = 27'sd4608000;
      1: v = 27'sd2720261;
      2: v = 27'sd1437311;
      3: v = 27'sd729602;
      4: v = 27'sd366217;
      5: v = 27'sd183287;
      6: v = 27'sd91666;
      7: v = 27'sd45836;
      8: v = 27'sd22918;
      9: v = 27'sd11459;
      10: v = 27'sd5730;
      11: v = 27'sd2865;
      12: v = 27'sd1432;
      13: v = 27'sd716;
      14: v = 27'sd358;
      15: v = 27'sd179;
      16: v = 27'sd90;
      17: v = 27'sd45;
      18: v = 27'sd22;
      19: v = 27'sd11;
      20: v = 27'sd6;
      21: v = 27'sd3;
      22: v = 27'sd1;
      23: v = 27'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

@@ rtl/tilt_and_heading_angles.sv @@
// tilt and compass heading pipeline: square root and three vectoring cordic lanes
// throughput: one sample per cycle, busy is never raised, the receiver cannot stall
// depth is set by the 24 square root digit stages and 16 cordic iteration stages
// reset: synchronous active low, clears valid bits and restores register defaults
`default_nettype none
module tilt_and_heading_angles (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic signed [15:0]  in_accel_x,
  input  wire logic signed [15:0]  in_accel_y,
  input  wire logic signed [15:0]  in_accel_z,
  input  wire logic signed [15:0]  in_mag_x,
  input  wire logic signed [15:0]  in_mag_y,
  input  wire logic signed [15:0]  in_mag_z,
  output logic                     out_valid,
  output logic signed [14:0]       out_pitch_angle,
  output logic signed [15:0]       out_roll_angle,
  output logic [15:0]              out_heading_angle,
  output logic [tah_pkg::DOT_W-1:0] out_dot_x,
  output logic [tah_pkg::DOT_W-1:0] out_dot_y,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_data
);
  import tah_pkg::*;
  `include "tilt_and_heading_angles_assert.svh"

  localparam logic signed [17:0] FULL_TURN = 18'sd36000;
  localparam logic signed [21:0] N_LIM = 22'(DISPLAY_SIZE * 100);
  localparam logic [DOT_W-1:0] DOT_MAX = DOT_W'(DISPLAY_SIZE - 1);

  logic accept;
  logic [S_OUT:0] v_r;
  logic signed [15:0] decl_r;
  logic [3:0] gain_r;
  logic [6:0] cx_r, cy_r;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      decl_r <= -16'sd494;
      gain_r <= 4'd3;
      cx_r <= 7'd64;
      cy_r <= 7'd64;
    end else begin
      v_r <= {v_r[S_OUT-1:0], accept};
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DECL: decl_r <= $signed(cfg_data);
          REG_GAIN: gain_r <= cfg_data[3:0];
          REG_CX: cx_r <= cfg_data[6:0];
          REG_CY: cy_r <= cfg_data[6:0];
          default: ;
        endcase
      end
    end
  end

  // input, squares, sum
  sample_t in_r, s1_r, s2_r;
  logic [30:0] sqy_r, sqz_r;
  logic [31:0] mag_r;

  always_ff @(posedge clk) begin
    in_r <= '{ax: in_accel_x, ay: in_accel_y, az: in_accel_z, mx: in_mag_x, my: in_mag_y};
    s1_r <= in_r;
    sqy_r <= 31'(in_r.ay * in_r.ay);
    sqz_r <= 31'(in_r.az * in_r.az);
    s2_r <= s1_r;
    mag_r <= 32'(sqy_r) + 32'(sqz_r);
  end

  // square root, one result bit per stage
  sample_t sq_c_r [0:SQ_BITS];
  logic [2*SQ_BITS-1:0] rad_r [0:SQ_BITS];
  logic [RW-1:0] rem_r [0:SQ_BITS];
  logic [SQ_BITS-1:0] root_r [0:SQ_BITS];

  always_comb begin
    sq_c_r[0] = s2_r;
    rad_r[0] = {mag_r, 16'b0};
    rem_r[0] = '0;
    root_r[0] = '0;
  end

  for (genvar j = 0; j < SQ_BITS; j++) begin : g_sqrt
    logic [RW+1:0] shl, trial;
    logic [RW-1:0] rem_nxt;
    logic [SQ_BITS-1:0] root_nxt;
    always_comb begin
      shl = {rem_r[j], rad_r[j][2*(SQ_BITS-1-j) +: 2]};
      trial = {{(RW-SQ_BITS){1'b0}}, root_r[j], 2'b01};
      if (shl >= trial) begin
        rem_nxt = RW'(shl - trial);
        root_nxt = {root_r[j][SQ_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = RW'(shl);
        root_nxt = {root_r[j][SQ_BITS-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      sq_c_r[j+1] <= sq_c_r[j];
      rad_r[j+1] <= rad_r[j];
      rem_r[j+1] <= rem_nxt;
      root_r[j+1] <= root_nxt;
    end
  end

  // quadrant fold and cordic lanes: 0 roll, 1 pitch, 2 heading
  function automatic cord_t prerot(input logic signed [CW-1:0] y, input logic signed [CW-1:0] x);
    cord_t c;
    c.zero = (x == '0) && (y == '0);
    c.x = x;
    c.y = y;
    c.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        c.x = y;
        c.y = -x;
        c.z = ZW'(QUARTER_Z);
      end else begin
        c.x = -y;
        c.y = x;
        c.z = -ZW'(QUARTER_Z);
      end
    end
    return c;
  endfunction

  cord_t lane_r [0:2][0:ANGLE_ITERATIONS];
  logic my0_r [0:ANGLE_ITERATIONS];
  logic mxpos_r [0:ANGLE_ITERATIONS];

  always_ff @(posedge clk) begin
    lane_r[0][0] <= prerot(CW'(sq_c_r[SQ_BITS].ay) <<< 8, CW'(sq_c_r[SQ_BITS].az) <<< 8);
    lane_r[1][0] <= prerot((-CW'(sq_c_r[SQ_BITS].ax)) <<< 16,
                           $signed(CW'(root_r[SQ_BITS])) <<< 8);
    lane_r[2][0] <= prerot((-CW'(sq_c_r[SQ_BITS].mx)) <<< 8, CW'(sq_c_r[SQ_BITS].my) <<< 8);
    my0_r[0] <= (sq_c_r[SQ_BITS].my == '0);
    mxpos_r[0] <= (sq_c_r[SQ_BITS].mx > 0);
  end

  for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_iter
    for (genvar l = 0; l < 3; l++) begin : g_lane
      cord_t c, n;
      always_comb begin
        c = lane_r[l][i];
        n = c;
        if (c.y >= 0) begin
          n.x = c.x + (c.y >>> i);
          n.y = c.y - (c.x >>> i);
          n.z = c.z + atan_tab(i);
        end else begin
          n.x = c.x - (c.y >>> i);
          n.y = c.y + (c.x >>> i);
          n.z = c.z - atan_tab(i);
        end
      end
      always_ff @(posedge clk) begin
        lane_r[l][i+1] <= n;
      end
    end
    always_ff @(posedge clk) begin
      my0_r[i+1] <= my0_r[i];
      mxpos_r[i+1] <= mxpos_r[i];
    end
  end

  // rounding and limits
  function automatic logic signed [15:0] rclamp(input cord_t c, input logic signed [15:0] lim);
    logic signed [ZW-1:0] r;
    logic signed [ZW-1:0] l;
    r = (c.z + ZW'(FRAC_HALF)) >>> FRAC_BITS;
    l = ZW'(lim);
    if (c.zero) r = '0;
    else if (r > l) r = l;
    else if (r < -l) r = -l;
    return 16'(r);
  endfunction

  logic signed [15:0] roll1_r, pitch1_r, head1_r;
  always_ff @(posedge clk) begin
    roll1_r <= rclamp(lane_r[0][ANGLE_ITERATIONS], 16'sd18000);
    pitch1_r <= rclamp(lane_r[1][ANGLE_ITERATIONS], 16'sd9000);
    if (my0_r[ANGLE_ITERATIONS]) head1_r <= mxpos_r[ANGLE_ITERATIONS] ? 16'sd18000 : 16'sd0;
    else head1_r <= rclamp(lane_r[2][ANGLE_ITERATIONS], 16'sd18000);
  end

  // declination, wrap and bubble offsets
  logic signed [17:0] hw;
  always_comb begin
    hw = 18'(head1_r) - 18'(decl_r);
    if (hw < 0) hw = hw + FULL_TURN;
    if (hw < 0) hw = hw + FULL_TURN;
    if (hw >= FULL_TURN) hw = hw - FULL_TURN;
  end

  logic signed [15:0] roll2_r, roll3_r;
  logic signed [14:0] pitch2_r, pitch3_r;
  logic [15:0] head2_r, head3_r;
  logic signed [21:0] offx_r, offy_r, cx100_r, cy100_r;
  always_ff @(posedge clk) begin
    roll2_r <= roll1_r;
    pitch2_r <= 15'(pitch1_r);
    head2_r <= 16'(hw);
    offx_r <= -(22'($signed({1'b0, gain_r})) * 22'(pitch1_r));
    offy_r <= 22'($signed({1'b0, gain_r})) * 22'(roll1_r);
    cx100_r <= $signed(22'(cx_r)) * 22'sd100;
    cy100_r <= $signed(22'(cy_r)) * 22'sd100;
  end

  logic signed [21:0] nx, ny;
  logic negx_r, negy_r, ovx_r, ovy_r;
  logic [16:0] nx_r, ny_r;
  assign nx = cx100_r + offx_r;
  assign ny = cy100_r + offy_r;
  always_ff @(posedge clk) begin
    roll3_r <= roll2_r;
    pitch3_r <= pitch2_r;
    head3_r <= head2_r;
    negx_r <= nx < 0;
    negy_r <= ny < 0;
    ovx_r <= nx >= N_LIM;
    ovy_r <= ny >= N_LIM;
    nx_r <= nx[16:0];
    ny_r <= ny[16:0];
  end

  // divide by 100 through a reciprocal
  logic [34:0] qx, qy;
  logic [DOT_W-1:0] dx, dy;
  always_comb begin
    qx = 35'(nx_r) * 35'(RECIP_100);
    qy = 35'(ny_r) * 35'(RECIP_100);
    dx = negx_r ? '0 : (ovx_r ? DOT_MAX : qx[RECIP_SH +: DOT_W]);
    dy = negy_r ? '0 : (ovy_r ? DOT_MAX : qy[RECIP_SH +: DOT_W]);
  end

  always_ff @(posedge clk) begin
    out_pitch_angle <= pitch3_r;
    out_roll_angle <= roll3_r;
    out_heading_angle <= head3_r;
    out_dot_x <= dx;
    out_dot_y <= dy;
  end
  assign out_valid = v_r[S_OUT];

  `TAH_ASSERT_IMPL(a_head_range, out_valid, out_heading_angle < 16'd36000)
  `TAH_ASSERT_IMPL(a_pitch_range, out_valid,
    (out_pitch_angle <= 15'sd9000) && (out_pitch_angle >= -15'sd9000))
  `TAH_ASSERT_IMPL(a_roll_range, out_valid,
    (out_roll_angle <= 16'sd18000) && (out_roll_angle >= -16'sd18000))
  `TAH_ASSERT_ALWAYS(a_never_busy, !busy && cfg_ready)
endmodule
`default_nettype wire
